// ----- rtl/alp_pkg.sv -----
// ----------------------------------------------------------------------------
// alp_pkg
// Shared widths, register codes, reset values and types of the address
// lease pool.
// ----------------------------------------------------------------------------
package alp_pkg;

   // Default number of pool entries
   localparam int ALP_POOL_DEPTH = 64;

   // Field widths
   localparam int ALP_ADDR_W      = 32;
   localparam int ALP_TIME_W      = 32;
   localparam int ALP_MAC_W       = 48;
   localparam int ALP_COUNT_W     = 7;
   localparam int ALP_INDEX_OUT_W = 6;

   // Configuration port
   localparam int ALP_CSR_INDEX_W = 8;
   localparam int ALP_CSR_DATA_W  = 32;

   localparam logic [ALP_CSR_INDEX_W-1:0] CSR_BASE_ADDRESS  = 8'd0;
   localparam logic [ALP_CSR_INDEX_W-1:0] CSR_SUBNET_MASK   = 8'd1;
   localparam logic [ALP_CSR_INDEX_W-1:0] CSR_LEASE_SECONDS = 8'd2;
   localparam logic [ALP_CSR_INDEX_W-1:0] CSR_POOL_COUNT    = 8'd3;

   // Register reset values
   localparam logic [ALP_ADDR_W-1:0]  RST_BASE_ADDRESS  = 32'h0000_0000;
   localparam logic [ALP_ADDR_W-1:0]  RST_SUBNET_MASK   = 32'hFFFF_FF00;
   localparam logic [ALP_TIME_W-1:0]  RST_LEASE_SECONDS = 32'd3600;
   localparam logic [ALP_COUNT_W-1:0] RST_POOL_COUNT    = 7'd64;

   // First host address handed out sits this far above the network base
   localparam logic [ALP_ADDR_W-1:0] HOST_OFFSET = 32'd51;

   // Configuration as seen by the scan engine
   typedef struct packed {
      logic [ALP_ADDR_W-1:0]  base_address;
      logic [ALP_ADDR_W-1:0]  subnet_mask;
      logic [ALP_TIME_W-1:0]  lease_seconds;
      logic [ALP_COUNT_W-1:0] pool_count;
   } alp_cfg_type;

endpackage

// ----- rtl/alp_req_if.sv -----
// ----------------------------------------------------------------------------
// alp_req_if
// Request channel: client hardware address and current time.
// ----------------------------------------------------------------------------
interface alp_req_if import alp_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [ALP_MAC_W-1:0]  client_mac;
   logic [ALP_TIME_W-1:0] now_seconds;

   modport source (output valid, client_mac, now_seconds, input ready);
   modport sink   (input valid, client_mac, now_seconds, output ready);

endinterface

// ----- rtl/alp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// alp_rsp_if
// Response channel: grant flag, offered address and entry index.
// ----------------------------------------------------------------------------
interface alp_rsp_if import alp_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic                       granted;
   logic [ALP_ADDR_W-1:0]      offered_ip;
   logic [ALP_INDEX_OUT_W-1:0] entry_index;

   modport source (output valid, granted, offered_ip, entry_index, input ready);
   modport sink   (input valid, granted, offered_ip, entry_index, output ready);

endinterface

// ----- rtl/address_lease_pool.sv -----
// ----------------------------------------------------------------------------
// address_lease_pool
// Address lease allocator. A request (req_ch) carries a client hardware
// address and the current time; the response (rsp_ch) tells whether an entry
// was granted, the offered address (network + 51 + index) and the index.
//
// Usage:
//  - Channels are valid/ready; a transfer happens when both are high.
//  - One request at a time: req_ch.ready is low from the request transfer
//    until the cycle after the response transfer.
//  - One entry per cycle through one expiry comparator: the scan grants the
//    first reusable entry, or refuses once min(pool_count, POOL_DEPTH)
//    entries have been checked.
//  - The response is held in registers until rsp_ch.ready; a stalled
//    receiver only delays the next request.
//  - After reset a clearing pass over all POOL_DEPTH entries marks every entry
//    free; no request is taken meanwhile. CSR writes (csr_*) land at once and
//    are to be made only while no request is in flight.
// ----------------------------------------------------------------------------
module address_lease_pool import alp_pkg::*; #(
   parameter int POOL_DEPTH = ALP_POOL_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [ALP_CSR_INDEX_W-1:0] csr_index,
   input  logic [ALP_CSR_DATA_W-1:0]  csr_write_data,
   alp_req_if.sink                    req_ch,
   alp_rsp_if.source                  rsp_ch
);

   alp_cfg_type cfg;

   // Configuration registers
   alp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Scan engine with lease tables
   alp_scan #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- rtl/alp_ram.sv -----
// ----------------------------------------------------------------------------
// alp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module alp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/alp_csr.sv -----
// ----------------------------------------------------------------------------
// alp_csr
// Configuration registers: base address, subnet mask, lease time, pool size.
// ----------------------------------------------------------------------------
module alp_csr import alp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [ALP_CSR_INDEX_W-1:0] csr_index,
   input  logic [ALP_CSR_DATA_W-1:0]  csr_write_data,
   output alp_cfg_type                cfg
);

   alp_cfg_type cfg_ff;
   alp_cfg_type cfg_in;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS:  cfg_in.base_address  = csr_write_data[ALP_ADDR_W-1:0];
            CSR_SUBNET_MASK:   cfg_in.subnet_mask   = csr_write_data[ALP_ADDR_W-1:0];
            CSR_LEASE_SECONDS: cfg_in.lease_seconds = csr_write_data[ALP_TIME_W-1:0];
            CSR_POOL_COUNT:    cfg_in.pool_count    = csr_write_data[ALP_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address  <= RST_BASE_ADDRESS;
         cfg_ff.subnet_mask   <= RST_SUBNET_MASK;
         cfg_ff.lease_seconds <= RST_LEASE_SECONDS;
         cfg_ff.pool_count    <= RST_POOL_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/alp_scan.sv -----
// ----------------------------------------------------------------------------
// alp_scan
// Lease scan engine: sequencer that walks the lease RAM one entry per cycle
// through a single expiry comparator and claims the first reusable entry.
// ----------------------------------------------------------------------------
module alp_scan import alp_pkg::*; #(
   parameter int POOL_DEPTH = ALP_POOL_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  alp_cfg_type cfg,
   alp_req_if.sink     req_ch,
   alp_rsp_if.source   rsp_ch
);

   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int LIM_W = (CNT_W > ALP_COUNT_W) ? CNT_W : ALP_COUNT_W;
   localparam int ENT_W = ALP_TIME_W + 1;   // {used, expiry}

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]           idx_ff, idx_in;       // read / clear pointer
   logic                       pend_ff, pend_in;     // read data in flight
   logic [IDX_W-1:0]           chk_ff, chk_in;       // entry under compare
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic [ALP_TIME_W-1:0]      now_ff, now_in;
   logic [ALP_TIME_W-1:0]      exp_ff, exp_in;
   logic [ALP_MAC_W-1:0]       mac_ff, mac_in;
   logic [ALP_ADDR_W-1:0]      net_ff, net_in;
   logic                       granted_ff, granted_in;
   logic [ALP_ADDR_W-1:0]      ip_ff, ip_in;
   logic [ALP_INDEX_OUT_W-1:0] index_ff, index_in;

   logic                       ent_wr_en;
   logic [IDX_W-1:0]           ent_wr_addr;
   logic [ENT_W-1:0]           ent_wr_data;
   logic                       ent_rd_en;
   logic [ENT_W-1:0]           ent_rd_data;
   logic                       cli_wr_en;

   logic [LIM_W-1:0]           count_wide;
   logic [LIM_W-1:0]           limit_wide;
   logic [ALP_TIME_W:0]        exp_sum;
   logic                       issue;
   logic                       hit;
   logic [ALP_ADDR_W-1:0]      chk_ext;

   // Pool size clamp and saturating expiry, taken at request transfer
   assign count_wide = LIM_W'(cfg.pool_count);
   assign limit_wide = (count_wide > LIM_W'(POOL_DEPTH)) ? LIM_W'(POOL_DEPTH) : count_wide;
   assign exp_sum    = {1'b0, req_ch.now_seconds} + {1'b0, cfg.lease_seconds};

   // Shared compare: entry free, or its lease has run out
   assign issue   = (idx_ff < limit_ff);
   assign hit     = pend_ff && (!ent_rd_data[ALP_TIME_W] ||
                                (now_ff >= ent_rd_data[ALP_TIME_W-1:0]));
   assign chk_ext = ALP_ADDR_W'(chk_ff);

   // Sequencer next state and RAM control
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      chk_in      = chk_ff;
      limit_in    = limit_ff;
      now_in      = now_ff;
      exp_in      = exp_ff;
      mac_in      = mac_ff;
      net_in      = net_ff;
      granted_in  = granted_ff;
      ip_in       = ip_ff;
      index_in    = index_ff;
      ent_wr_en   = 1'b0;
      ent_wr_addr = chk_ff;
      ent_wr_data = {1'b1, exp_ff};
      ent_rd_en   = 1'b0;
      cli_wr_en   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = idx_ff[IDX_W-1:0];
            ent_wr_data = '0;
            if (idx_ff == CNT_W'(POOL_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               limit_in = limit_wide[CNT_W-1:0];
               now_in   = req_ch.now_seconds;
               exp_in   = exp_sum[ALP_TIME_W] ? '1 : exp_sum[ALP_TIME_W-1:0];
               mac_in   = req_ch.client_mac;
               net_in   = (cfg.base_address & cfg.subnet_mask) + HOST_OFFSET;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ent_rd_en = issue;
            if (hit) begin
               // Claim the entry under compare
               ent_wr_en  = 1'b1;
               cli_wr_en  = 1'b1;
               granted_in = 1'b1;
               ip_in      = net_ff + chk_ext;
               index_in   = ALP_INDEX_OUT_W'(chk_ext);
               pend_in    = 1'b0;
               state_in   = ST_RESP;
            end else if (issue || pend_ff) begin
               pend_in = issue;
               chk_in  = idx_ff[IDX_W-1:0];
               if (issue) begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               // Pool exhausted
               granted_in = 1'b0;
               ip_in      = '0;
               index_in   = '0;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
      chk_ff     <= chk_in;
      limit_ff   <= limit_in;
      now_ff     <= now_in;
      exp_ff     <= exp_in;
      mac_ff     <= mac_in;
      net_ff     <= net_in;
      granted_ff <= granted_in;
      ip_ff      <= ip_in;
      index_ff   <= index_in;
   end

   // Lease table: used flag and expiry time per entry
   alp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (POOL_DEPTH)
   ) u_lease_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ent_rd_data)
   );

   // Client table: hardware address of the lease holder
   alp_ram #(
      .WIDTH (ALP_MAC_W),
      .DEPTH (POOL_DEPTH)
   ) u_client_ram (
      .clock   (clock),
      .wr_en   (cli_wr_en),
      .wr_addr (chk_ff),
      .wr_data (mac_ff),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_RESP);
   assign rsp_ch.granted     = granted_ff;
   assign rsp_ch.offered_ip  = ip_ff;
   assign rsp_ch.entry_index = index_ff;

endmodule

// ----- sim/alp_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// alp_tb_pkg
// Lease ledger for the address lease pool bench: a cycle-free model of the
// pool that works out the offer for each request and checks the offers the
// block returns, in order, field by field.
// ----------------------------------------------------------------------------
package alp_tb_pkg;
   import alp_pkg::*;

   // One offer as the response channel carries it
   typedef struct packed {
      logic                       granted;
      logic [ALP_ADDR_W-1:0]      offered_ip;
      logic [ALP_INDEX_OUT_W-1:0] entry_index;
   } lease_offer_type;

   class lease_ledger;
      // Register copy
      logic [ALP_ADDR_W-1:0]  base_address;
      logic [ALP_ADDR_W-1:0]  subnet_mask;
      logic [ALP_TIME_W-1:0]  lease_seconds;
      logic [ALP_COUNT_W-1:0] pool_count;

      // Pool copy
      bit                    entry_used   [ALP_POOL_DEPTH];
      logic [ALP_TIME_W-1:0] entry_expiry [ALP_POOL_DEPTH];
      logic [ALP_MAC_W-1:0]  entry_client [ALP_POOL_DEPTH];

      // Offers still owed by the block, oldest first
      lease_offer_type expected_offers[$];

      int unsigned mismatches;
      int unsigned requests;
      int unsigned grants;
      int unsigned refusals;
      int unsigned reclaimed;
      int unsigned saturated;

      function new();
         base_address  = RST_BASE_ADDRESS;
         subnet_mask   = RST_SUBNET_MASK;
         lease_seconds = RST_LEASE_SECONDS;
         pool_count    = RST_POOL_COUNT;
         for (int i = 0; i < ALP_POOL_DEPTH; i++) begin
            entry_used[i]   = 1'b0;
            entry_expiry[i] = '0;
            entry_client[i] = '0;
         end
         mismatches = 0;
         requests   = 0;
         grants     = 0;
         refusals   = 0;
         reclaimed  = 0;
         saturated  = 0;
      endfunction

      // Register write; unknown indexes leave everything as it was
      function void write_register(logic [ALP_CSR_INDEX_W-1:0] index,
                                   logic [ALP_CSR_DATA_W-1:0] value);
         case (index)
            CSR_BASE_ADDRESS:  base_address  = value;
            CSR_SUBNET_MASK:   subnet_mask   = value;
            CSR_LEASE_SECONDS: lease_seconds = value;
            CSR_POOL_COUNT:    pool_count    = value[ALP_COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Scan the pool for one accepted request and queue the offer it earns
      function void record_request(logic [ALP_MAC_W-1:0] mac, logic [ALP_TIME_W-1:0] now);
         int                    limit;
         logic [ALP_ADDR_W-1:0] network;
         logic [ALP_TIME_W:0]   expiry_sum;
         lease_offer_type       offer;
         limit   = (pool_count > ALP_POOL_DEPTH) ? ALP_POOL_DEPTH : int'(pool_count);
         network = base_address & subnet_mask;
         offer   = '0;
         requests++;
         for (int i = 0; i < limit; i++) begin
            // expired lease is dropped as the scan passes it
            if (entry_used[i] && now >= entry_expiry[i]) begin
               entry_used[i]   = 1'b0;
               entry_client[i] = '0;
               reclaimed++;
            end
            if (!entry_used[i]) begin
               expiry_sum      = {1'b0, now} + {1'b0, lease_seconds};
               entry_used[i]   = 1'b1;
               entry_client[i] = mac;
               entry_expiry[i] = expiry_sum[ALP_TIME_W] ? '1 : expiry_sum[ALP_TIME_W-1:0];
               if (expiry_sum[ALP_TIME_W]) saturated++;
               offer.granted     = 1'b1;
               offer.offered_ip  = network + HOST_OFFSET + ALP_ADDR_W'(i);
               offer.entry_index = ALP_INDEX_OUT_W'(i);
               break;
            end
         end
         if (offer.granted) grants++;
         else refusals++;
         expected_offers.push_back(offer);
      endfunction

      // Compare one returned offer against the oldest one owed
      function void check_offer(logic granted, logic [ALP_ADDR_W-1:0] offered_ip,
                                logic [ALP_INDEX_OUT_W-1:0] entry_index);
         lease_offer_type owed;
         if (expected_offers.size() == 0) begin
            mismatches++;
            $display("%0t: offer with no request outstanding: granted %0b ip %h index %0d",
                     $time, granted, offered_ip, entry_index);
            return;
         end
         owed = expected_offers.pop_front();
         if (granted !== owed.granted) begin
            mismatches++;
            $display("%0t: granted expected %0b actual %0b", $time, owed.granted, granted);
         end
         if (offered_ip !== owed.offered_ip) begin
            mismatches++;
            $display("%0t: offered_ip expected %h actual %h", $time, owed.offered_ip,
                     offered_ip);
         end
         if (entry_index !== owed.entry_index) begin
            mismatches++;
            $display("%0t: entry_index expected %0d actual %0d", $time, owed.entry_index,
                     entry_index);
         end
      endfunction
   endclass

endpackage

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Bench for address_lease_pool. A directed opening walks through pool
// exhaustion, expiry on the scan path, early stop, an empty and an oversized
// pool, address wrap, zero and saturating leases and writes to unmapped
// registers; then randomized phases with fresh register settings send
// requests on a mostly advancing clock so that leases fill, expire and are
// reused. Both channels idle at random, with one phase running flat out.
// ----------------------------------------------------------------------------
module tb;
   import alp_pkg::*;
   import alp_tb_pkg::*;

   localparam int IDLE_PERCENT  = 25;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = ALP_POOL_DEPTH + 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 104;
   localparam int STEADY_PHASE  = 3;

   localparam logic [ALP_CSR_INDEX_W-1:0] CSR_FIRST_UNMAPPED = 8'd4;
   localparam logic [ALP_CSR_INDEX_W-1:0] CSR_LAST_UNMAPPED  = 8'hFF;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [ALP_CSR_INDEX_W-1:0] csr_index;
   logic [ALP_CSR_DATA_W-1:0]  csr_write_data;

   bit                    steady_run;
   int unsigned           csr_writes;
   int unsigned           quiet_cycles;
   logic [ALP_TIME_W-1:0] now_clock;

   alp_req_if req_ch ();
   alp_rsp_if rsp_ch ();

   lease_ledger ledger = new();

   address_lease_pool DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Response side: random back-pressure, none during the steady phase
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = steady_run || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Check every offer transfer
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ledger.check_offer(rsp_ch.granted, rsp_ch.offered_ip, rsp_ch.entry_index);
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("address_lease_pool verification failed");
         $finish;
      end
   end

   // One register write, taken at the next rising edge
   task automatic write_csr(input logic [ALP_CSR_INDEX_W-1:0] index,
                            input logic [ALP_CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      ledger.write_register(index, data);
      csr_writes++;
   endtask

   task automatic load_config(input logic [ALP_CSR_DATA_W-1:0] base,
                              input logic [ALP_CSR_DATA_W-1:0] mask,
                              input logic [ALP_CSR_DATA_W-1:0] lease,
                              input logic [ALP_CSR_DATA_W-1:0] count);
      write_csr(CSR_BASE_ADDRESS, base);
      write_csr(CSR_SUBNET_MASK, mask);
      write_csr(CSR_LEASE_SECONDS, lease);
      write_csr(CSR_POOL_COUNT, count);
   endtask

   // One request transfer, with a random lead-in gap
   task automatic send_request(input logic [ALP_MAC_W-1:0] mac,
                               input logic [ALP_TIME_W-1:0] now);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.client_mac  = mac;
      req_ch.now_seconds = now;
      do @(posedge clock); while (!req_ch.ready);
      ledger.record_request(mac, now);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Block is idle once every owed offer has come back
   task automatic wait_offers_done();
      while (ledger.expected_offers.size() != 0) @(negedge clock);
   endtask

   function automatic logic [ALP_MAC_W-1:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Mostly small forward steps, some repeats, rare jumps and the top of time
   function automatic logic [ALP_TIME_W-1:0] next_time(input logic [ALP_TIME_W-1:0] t);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 2) return '1;
      if (pick < 7) return $urandom;
      if (pick < 17) return t;
      if (pick < 85) return t + $urandom_range(0, 20);
      return t + $urandom_range(21, 400);
   endfunction

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.client_mac  = '0;
      req_ch.now_seconds = '0;
      steady_run         = 1'b0;
      csr_writes         = 0;
      quiet_cycles       = 0;
      now_clock          = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, first entries and the all-ones request
      send_request('0, '0);
      send_request(48'h0000_0000_0001, 32'd1);
      send_request('1, '1);
      wait_offers_done();

      // Small pool: fill up, then expiry with early stop, then a refusal
      load_config(32'hC0A8_0105, 32'hFFFF_FF00, 32'd10, 32'd3);
      send_request(48'hA5A5_A5A5_A5A5, 32'd1000);
      send_request(48'h5A5A_5A5A_5A5A, 32'd1005);
      send_request(48'h0123_4567_89AB, 32'd1006);
      send_request(48'hFEDC_BA98_7654, 32'd3600);
      send_request(48'h1111_2222_3333, 32'd3601);
      send_request(48'h4444_5555_6666, 32'd3601);
      send_request(48'h7777_8888_9999, 32'd3601);
      wait_offers_done();

      // Empty pool, then an oversized count with stray high bits
      write_csr(CSR_POOL_COUNT, 32'd0);
      send_request(random_mac(), 32'd5000);
      wait_offers_done();
      write_csr(CSR_POOL_COUNT, 32'hFFFF_FFC5);
      send_request(random_mac(), 32'd5000);
      wait_offers_done();

      // Writes to unmapped indexes must change nothing
      write_csr(CSR_FIRST_UNMAPPED, '0);
      write_csr(CSR_LAST_UNMAPPED, '1);
      send_request(random_mac(), 32'd5000);
      wait_offers_done();

      // Address wrap with an all-ones network and zero-length leases
      load_config('1, '1, '0, ALP_POOL_DEPTH);
      send_request(random_mac(), 32'd6000);
      send_request(random_mac(), 32'd6000);
      send_request(random_mac(), 32'd6001);
      wait_offers_done();

      // Zero mask, then a saturating lease and the largest count
      load_config(32'h1234_5678, '0, 32'd100, 32'd5);
      send_request(random_mac(), 32'd7000);
      send_request(random_mac(), 32'd7000);
      wait_offers_done();
      write_csr(CSR_LEASE_SECONDS, '1);
      write_csr(CSR_POOL_COUNT, 32'd127);
      send_request('1, 32'hFFFF_FFF0);
      send_request('0, '1);
      wait_offers_done();

      // Random phases, each with its own register settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         logic [ALP_CSR_DATA_W-1:0] base;
         logic [ALP_CSR_DATA_W-1:0] mask;
         logic [ALP_CSR_DATA_W-1:0] lease;
         logic [ALP_CSR_DATA_W-1:0] count;
         int unsigned               prefix;
         prefix    = $urandom_range(0, 32);
         base      = $urandom;
         mask      = (prefix == 0) ? '0 : ~32'h0 << (32 - prefix);
         lease     = $urandom_range(1, 200);
         count     = $urandom_range(1, 12);
         now_clock = $urandom_range(0, 100000);
         case (phase)
            0: base = '0;
            1: mask = '0;
            2: begin
               base = '1;
               mask = '1;
            end
            4: lease = '0;
            5: count = ALP_POOL_DEPTH;
            6: count = {25'($urandom), 7'($urandom_range(ALP_POOL_DEPTH + 1, 127))};
            // saturated leases expire only at the top of time, so this phase comes last
            7: begin
               lease     = '1;
               now_clock = 32'hFFFF_FF00;
            end
            default: ;
         endcase
         load_config(base, mask, lease, count);
         write_csr(8'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED)), $urandom);
         steady_run = (phase == STEADY_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            now_clock = next_time(now_clock);
            send_request(random_mac(), now_clock);
         end
         wait_offers_done();
         steady_run = 1'b0;
      end

      // Let any stray offer show up before the verdict
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (ledger.expected_offers.size() != 0) begin
         ledger.mismatches++;
         $display("%0t: %0d offers never returned", $time, ledger.expected_offers.size());
      end

      $display("Covered %0d requests: %0d granted, %0d refused, %0d leases reclaimed",
               ledger.requests, ledger.grants, ledger.refusals, ledger.reclaimed);
      $display("%0d saturated expiries, %0d register writes, %0d mismatches",
               ledger.saturated, csr_writes, ledger.mismatches);
      if (ledger.mismatches == 0)
         $display("address_lease_pool verification clean");
      else
         $display("address_lease_pool verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/alp_pkg.sv
rtl/alp_req_if.sv
rtl/alp_rsp_if.sv
rtl/alp_ram.sv
rtl/alp_csr.sv
rtl/alp_scan.sv
rtl/address_lease_pool.sv
sim/alp_tb_pkg.sv
sim/tb.sv
